FILE: hw/rtl/b100_pkg.sv
`timescale 1ns / 1ps

package b100_pkg;

  // Sizing of one stored number and of its text.
  localparam int MAX_BYTES  = 21;
  localparam int MAX_CHARS  = 44;
  localparam int TEXT_LIMIT = (MAX_CHARS < 45) ? MAX_CHARS : 45;

  // Byte codes of the stored format.
  localparam logic [7:0] ZERO_BYTE = 8'h80;
  localparam logic [7:0] NEG_TERM  = 8'd102;
  localparam logic [6:0] EXP_BIAS  = 7'd64;

  // ASCII codes.
  localparam logic [6:0] ASC_ZERO  = 7'h30;
  localparam logic [6:0] ASC_MINUS = 7'h2D;
  localparam logic [6:0] ASC_DOT   = 7'h2E;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DIGIT  = 3'd1,
    ST_EXP    = 3'd2,
    ST_LONG   = 3'd3,
    ST_BYTES  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CH_ZERO,
    CH_MINUS,
    CH_DOT,
    CH_TENS,
    CH_ONES
  } char_sel_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic      load;
    logic      skip;
    logic      set_sign;
    logic      put;
    char_sel_t sel;
    logic      lead_load;
    logic      pad_load;
    logic      zdec;
    logic      set_err;
    status_t   err_val;
    logic      push_hold;
    logic      hold_end;
    logic      push_err;
    logic      push_mark;
    logic      finish;
    logic      fail;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic skip;
    logic first;
    logic over;
    logic lone;
    logic neg;
    logic le64;
    logic last;
    logic neg_term;
    logic dot_here;
    logic val_ok;
    logic has_tens;
    logic lead_zero;
    logic pad_need;
    logic pad_big;
    logic zcnt_zero;
    logic at_limit;
    logic hold_valid;
    logic out_free;
  } stat_t;

  // Tens digit of a value below 100 by reciprocal multiplication.
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] prod;
    prod = {8'd0, v} * 15'd205;
    return prod[14:11];
  endfunction

endpackage

FILE: hw/rtl/b100_dp.sv
`timescale 1ns / 1ps

module b100_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       s_tdata,   // byte_value[7:0]
  input  logic             s_tlast,
  input  b100_pkg::cmd_t   cmd,
  output b100_pkg::stat_t  stat,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // char_code[6:0], zero[7]
  output logic             m_tlast,
  output logic [2:0]       m_tuser    // status[2:0]
);
  import b100_pkg::*;

  logic [4:0] byte_index;
  logic       is_negative;
  logic [6:0] exponent;
  logic [5:0] chars_emitted;
  logic       failed_skip;
  logic [7:0] b_r;
  logic       last_r;
  logic [6:0] hold_char;
  logic       hold_valid;
  logic [7:0] zcnt;
  status_t    err_code;
  logic [6:0] out_char;

  logic [7:0] val8;
  logic [6:0] val7;
  logic       val_ok;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [6:0] put_char;
  logic [6:0] room;
  logic [6:0] lim;
  logic [6:0] e_pos;
  logic       out_free;
  logic       push_any;

  assign val8 = is_negative ? (8'd101 - b_r) : (b_r - 8'd1);
  assign val7 = val8[6:0];
  assign val_ok = is_negative ? (b_r >= 8'd2 && b_r <= 8'd101)
                              : (b_r >= 8'd1 && b_r <= 8'd100);
  assign tens = tens_of(val7);
  assign ones = 4'(val7 - {tens, 3'b000} - {2'b00, tens, 1'b0});

  always_comb begin
    unique case (cmd.sel)
      CH_ZERO:  put_char = ASC_ZERO;
      CH_MINUS: put_char = ASC_MINUS;
      CH_DOT:   put_char = ASC_DOT;
      CH_TENS:  put_char = ASC_ZERO + {3'b000, tens};
      CH_ONES:  put_char = ASC_ZERO + {3'b000, ones};
      default:  put_char = ASC_ZERO;
    endcase
  end

  // Room left for trailing zero pairs, in pairs.
  assign room  = 7'(TEXT_LIMIT - 1) - {1'b0, chars_emitted};
  assign lim   = ({1'b0, chars_emitted} >= 7'(TEXT_LIMIT - 1)) ? 7'd0 : {1'b0, room[6:1]};
  assign e_pos = exponent - EXP_BIAS;

  assign out_free = !m_tvalid || m_tready;
  assign push_any = cmd.push_hold || cmd.push_err || cmd.push_mark ||
                    (cmd.put && hold_valid);

  always_comb begin
    stat.skip       = failed_skip;
    stat.first      = (byte_index == 5'd0);
    stat.over       = (byte_index >= 5'(MAX_BYTES));
    stat.lone       = last_r && (b_r == ZERO_BYTE);
    stat.neg        = is_negative;
    stat.le64       = (exponent <= EXP_BIAS);
    stat.last       = last_r;
    stat.neg_term   = is_negative && (b_r == NEG_TERM) && last_r;
    stat.dot_here   = (exponent == ({2'b00, byte_index} + 7'd63)) && (exponent != EXP_BIAS);
    stat.val_ok     = val_ok;
    stat.has_tens   = (val7 >= 7'd10);
    stat.lead_zero  = (exponent <= EXP_BIAS) || (byte_index != 5'd1);
    stat.pad_need   = ({1'b0, exponent} >= ({3'b000, byte_index} + 8'd65));
    stat.pad_big    = (e_pos > lim);
    stat.zcnt_zero  = (zcnt == 8'd0);
    stat.at_limit   = (chars_emitted >= 6'(TEXT_LIMIT));
    stat.hold_valid = hold_valid;
    stat.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      is_negative   <= 1'b0;
      exponent      <= '0;
      chars_emitted <= '0;
      failed_skip   <= 1'b0;
      hold_valid    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cmd.load) begin
        b_r    <= s_tdata;
        last_r <= s_tlast;
      end
      if (cmd.skip) begin
        if (s_tlast) begin
          byte_index    <= '0;
          is_negative   <= 1'b0;
          exponent      <= '0;
          chars_emitted <= '0;
          failed_skip   <= 1'b0;
        end else begin
          byte_index <= byte_index + 5'd1;
        end
      end
      if (cmd.set_sign) begin
        is_negative <= !b_r[7];
        exponent    <= b_r[7] ? b_r[6:0] : ~b_r[6:0];
      end
      if (cmd.put) begin
        hold_char     <= put_char;
        hold_valid    <= 1'b1;
        chars_emitted <= chars_emitted + 6'd1;
      end else if (cmd.push_hold) begin
        hold_valid <= 1'b0;
      end
      if (cmd.lead_load) begin
        zcnt <= {EXP_BIAS - exponent, 1'b0};
      end else if (cmd.pad_load) begin
        zcnt <= {e_pos - {2'b00, byte_index}, 1'b0};
      end else if (cmd.zdec) begin
        zcnt <= zcnt - 8'd1;
      end
      if (cmd.set_err) begin
        err_code <= cmd.err_val;
      end
      if (cmd.finish) begin
        if (last_r) begin
          byte_index    <= '0;
          is_negative   <= 1'b0;
          exponent      <= '0;
          chars_emitted <= '0;
          failed_skip   <= 1'b0;
        end else begin
          byte_index  <= byte_index + 5'd1;
          failed_skip <= cmd.fail;
        end
      end
      if (push_any) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.push_err) begin
      out_char <= '0;
      m_tlast  <= 1'b1;
      m_tuser  <= err_code;
    end else if (cmd.push_mark) begin
      out_char <= '0;
      m_tlast  <= 1'b1;
      m_tuser  <= ST_OK;
    end else if (cmd.push_hold || (cmd.put && hold_valid)) begin
      out_char <= hold_char;
      m_tlast  <= cmd.push_hold && cmd.hold_end;
      m_tuser  <= ST_OK;
    end
  end

  assign m_tdata = {1'b0, out_char};

endmodule

FILE: hw/rtl/b100_ctrl.sv
`timescale 1ns / 1ps

module b100_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  b100_pkg::stat_t  stat,
  output b100_pkg::cmd_t   cmd
);
  import b100_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_LONE,
    S_SIGN,
    S_ZERO0,
    S_DOT0,
    S_LEADZ,
    S_DOT,
    S_DIG,
    S_ONES,
    S_FINAL,
    S_PAD,
    S_END,
    S_ERR
  } state_t;

  state_t    state;
  state_t    state_next;
  state_t    put_next;
  logic      want_put;
  char_sel_t put_sel;
  logic      put_go;

  assign s_tready = (state == S_IDLE);
  assign put_go   = !stat.hold_valid || stat.out_free;

  always_comb begin
    cmd        = '0;
    cmd.sel    = CH_ZERO;
    cmd.err_val = ST_OK;
    state_next = state;
    want_put   = 1'b0;
    put_sel    = CH_ZERO;
    put_next   = state;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (stat.skip) begin
            cmd.skip = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (stat.over) begin
          cmd.set_err = 1'b1;
          cmd.err_val = ST_BYTES;
          state_next  = S_ERR;
        end else if (stat.first) begin
          if (stat.lone) begin
            state_next = S_LONE;
          end else begin
            cmd.set_sign = 1'b1;
            state_next   = S_SIGN;
          end
        end else if (stat.neg_term) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_DOT;
        end
      end
      S_LONE: begin
        want_put = 1'b1;
        put_next = S_END;
      end
      S_SIGN: begin
        if (stat.neg) begin
          want_put = 1'b1;
          put_sel  = CH_MINUS;
          put_next = S_ZERO0;
        end else begin
          state_next = S_ZERO0;
        end
      end
      S_ZERO0: begin
        if (stat.le64) begin
          want_put = 1'b1;
          put_next = stat.last ? S_FINAL : S_DOT0;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_DOT0: begin
        want_put      = 1'b1;
        put_sel       = CH_DOT;
        put_next      = S_LEADZ;
        cmd.lead_load = 1'b1;
      end
      S_LEADZ: begin
        if (stat.zcnt_zero) begin
          state_next = S_FINAL;
        end else begin
          want_put = 1'b1;
          put_next = S_LEADZ;
        end
      end
      S_DOT: begin
        if (stat.dot_here) begin
          want_put = 1'b1;
          put_sel  = CH_DOT;
          put_next = S_DIG;
        end else begin
          state_next = S_DIG;
        end
      end
      S_DIG: begin
        if (!stat.val_ok) begin
          cmd.set_err = 1'b1;
          cmd.err_val = ST_DIGIT;
          state_next  = S_ERR;
        end else if (stat.has_tens) begin
          want_put = 1'b1;
          put_sel  = CH_TENS;
          put_next = S_ONES;
        end else if (stat.lead_zero) begin
          want_put = 1'b1;
          put_next = S_ONES;
        end else begin
          state_next = S_ONES;
        end
      end
      S_ONES: begin
        want_put = 1'b1;
        put_sel  = CH_ONES;
        put_next = S_FINAL;
      end
      S_FINAL: begin
        if (stat.last && stat.pad_need) begin
          if (stat.pad_big) begin
            cmd.set_err = 1'b1;
            cmd.err_val = ST_EXP;
            state_next  = S_ERR;
          end else begin
            cmd.pad_load = 1'b1;
            state_next   = S_PAD;
          end
        end else begin
          state_next = S_END;
        end
      end
      S_PAD: begin
        if (stat.zcnt_zero) begin
          state_next = S_END;
        end else begin
          want_put = 1'b1;
          put_next = S_PAD;
        end
      end
      S_END: begin
        if (stat.hold_valid) begin
          if (stat.out_free) begin
            cmd.push_hold = 1'b1;
            cmd.hold_end  = stat.last;
            cmd.finish    = 1'b1;
            state_next    = S_IDLE;
          end
        end else if (stat.last) begin
          if (stat.out_free) begin
            cmd.push_mark = 1'b1;
            cmd.finish    = 1'b1;
            state_next    = S_IDLE;
          end
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.out_free) begin
          if (stat.hold_valid) begin
            cmd.push_hold = 1'b1;
          end else begin
            cmd.push_err = 1'b1;
            cmd.finish   = 1'b1;
            cmd.fail     = 1'b1;
            state_next   = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Common character step: the text limit turns a character into an error.
    if (want_put) begin
      if (stat.at_limit) begin
        cmd.set_err = 1'b1;
        cmd.err_val = ST_LONG;
        state_next  = S_ERR;
      end else if (put_go) begin
        cmd.put    = 1'b1;
        cmd.sel    = put_sel;
        cmd.zdec   = (state == S_LEADZ) || (state == S_PAD);
        state_next = put_next;
      end else begin
        cmd.lead_load = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/base100_number_bytes_to_decimal_text.sv
`timescale 1ns / 1ps
// A formed character waits in the hold register and moves on to the output register, once
// that is free, when the next character is formed or the byte is done; a byte's beat is
// first loaded into the byte register and decoded by the sequencer before its first character
// is formed. The sequencer forms at most one character per cycle and takes one byte at a time,
// so a new byte waits until the last one is done; bytes dropped after an error go straight.
// Reset: synchronous, active high; clears the sequencer, the number state and the output.

module base100_number_bytes_to_decimal_text (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // byte_value[7:0]
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // char_code[6:0], zero fill[7]
  output logic       m_tlast,   // end_of_text
  output logic [2:0] m_tuser    // status[2:0]
);
  import b100_pkg::*;

  // The sequencer walks through the pieces of text that one byte can produce:
  // sign, leading "0." with zero pairs, decimal point, the digit pair, and the
  // trailing "00" pairs after the final byte. Each formed character sits in a
  // one-character hold stage inside the datapath until the next one is formed
  // or the byte is done, so the last character of a number can carry its
  // end-of-text mark. Errors flush the held character and send one error beat;
  // the remaining bytes of that number are then dropped at one per cycle.

  cmd_t  cmd;
  stat_t stat;

  b100_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The output register lets the next byte be taken while a beat still waits.
  b100_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: hw/rtl/b100_chk.sv
`timescale 1ns / 1ps

module b100_chk (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tlast,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast,
  input logic [2:0] m_tuser
);
  import b100_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                              $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_OK) |-> m_tlast && (m_tdata == 8'd0))
    else $error("error beat without end of text or with a character");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_BYTES) && !m_tdata[7])
    else $error("status or character out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind base100_number_bytes_to_decimal_text b100_chk u_chk (.*);
